// ===== sv/bmsd_pkg.sv =====
// Shared types and constants for the button matrix scanner with debounce.
// Used by the front, queue, back and top modules; no dependencies.
package bmsd_pkg;

  localparam int NUM_MATRICES = 4;
  localparam int ROWS         = 8;
  localparam int MATRIX_W     = 2;
  localparam int ROW_W        = 3;
  localparam int SLOT_W       = MATRIX_W + ROW_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] DEBOUNCE_DEFAULT = 8'd10;
  localparam logic [7:0] ALL_RELEASED     = 8'hff;
  localparam logic [6:0] VEL_PRESS        = 7'h7f;

  // register indexes on the config port (byte address / 4)
  localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd0;
  localparam logic [1:0] REG_NOTE_BASE     = 2'd1;
  localparam logic [1:0] REG_MIDI_CHANNEL  = 2'd2;

  typedef struct packed {
    logic [1:0] matrix_index;
    logic [7:0] row_bits;
    logic       end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic [7:0] row_drive;
    logic       event_valid;
    logic [1:0] event_matrix;
    logic [5:0] key_number;
    logic       released;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic [3:0] event_channel;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lockout_ticks;
    logic [6:0] note_base;
    logic [3:0] midi_channel;
  } cfg_t;

  // classified row handed from front to back
  typedef struct packed {
    logic [7:0]          drive;
    logic [MATRIX_W-1:0] matrix;
    logic [ROW_W-1:0]    row;
    logic [7:0]          changed;
    logic [7:0]          now;
  } job_t;

endpackage

// ===== sv/bmsd_front.sv =====
// Front end: accepts row beats, runs debounce and stored-state compare.
// Depends on bmsd_pkg; pushes one job per beat into bmsd_queue.
module bmsd_front import bmsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       dcnt_r  [NUM_MATRICES];
  logic [7:0]       state_r [NUM_MATRICES*ROWS];

  logic             in_range;
  logic [SLOT_W-1:0] slot;
  logic [7:0]       cnt_dec;
  logic [7:0]       stored;
  logic [7:0]       changed;
  logic             active;

  assign q_push   = in_valid && !q_full;
  assign in_range = {1'b0, in_data.matrix_index} < (MATRIX_W+1)'(NUM_MATRICES);
  assign slot     = {in_data.matrix_index, row_r};
  assign stored   = state_r[slot];

  always_comb begin
    cnt_dec = dcnt_r[in_data.matrix_index];
    if (cnt_dec != 8'd0) begin
      cnt_dec = cnt_dec - 8'd1;
    end
    active  = in_range && (cnt_dec == 8'd0);
    changed = active ? (in_data.row_bits ^ stored) : 8'd0;
    row_nxt = in_data.end_of_scan ? row_r + ROW_W'(1) : row_r;
  end

  always_comb begin
    q_job.drive   = ~(8'd1 << row_nxt);
    q_job.matrix  = in_data.matrix_index;
    q_job.row     = row_r;
    q_job.changed = changed;
    q_job.now     = in_data.row_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      for (int i = 0; i < NUM_MATRICES; i++) begin
        dcnt_r[i] <= '0;
      end
      for (int i = 0; i < NUM_MATRICES*ROWS; i++) begin
        state_r[i] <= ALL_RELEASED;
      end
    end else if (q_push) begin
      row_r <= row_nxt;
      if (in_range) begin
        if (active) begin
          state_r[slot] <= in_data.row_bits;
          dcnt_r[in_data.matrix_index] <= (changed != 8'd0) ? cfg.lockout_ticks : 8'd0;
        end else begin
          dcnt_r[in_data.matrix_index] <= cnt_dec;
        end
      end
    end
  end

endmodule

// ===== sv/bmsd_queue.sv =====
// Short job queue between the front and back ends.
// Depends on bmsd_pkg for the job type and depth.
module bmsd_queue import bmsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/bmsd_back.sv =====
// Back end: walks a job's changed pins lowest first, one result beat per cycle within a job while not stalled.
// Depends on bmsd_pkg; pops jobs from bmsd_queue, owns the output register.
module bmsd_back import bmsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_not_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      job_valid_r;
  job_t      job_r;
  logic [7:0] rem_r, rem_nxt;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  logic      step;
  logic [7:0] low_bit;
  logic [2:0] pin;
  logic [5:0] key;
  logic      rel;

  function automatic logic [2:0] low_pin(input logic [7:0] m);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = q_not_empty && !job_valid_r;
  assign step      = job_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    low_bit = rem_r & (~rem_r + 8'd1);
    rem_nxt = rem_r & ~low_bit;
    pin     = low_pin(rem_r);
    key     = {job_r.row, pin};
    rel     = job_r.now[pin];
    out_nxt = '0;
    out_nxt.row_drive = job_r.drive;
    if (rem_r != 8'd0) begin
      out_nxt.event_valid   = 1'b1;
      out_nxt.event_matrix  = job_r.matrix;
      out_nxt.key_number    = key;
      out_nxt.released      = rel;
      out_nxt.note_number   = cfg.note_base + {1'b0, key};
      out_nxt.velocity      = rel ? 7'd0 : VEL_PRESS;
      out_nxt.event_channel = cfg.midi_channel;
      out_nxt.last_result   = rem_nxt == 8'd0;
    end else begin
      out_nxt.last_result   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
      end else if (step && out_nxt.last_result) begin
        job_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
      rem_r <= q_head.changed;
    end else if (step) begin
      rem_r <= rem_nxt;
    end
    if (step) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== sv/button_matrix_scan_debounce.sv =====
// Button matrix scanner with debounce: top level, config registers, assertions.
// Row beat path: job queue, back-end job register, then the output register (idle back end).
// The back-end serializer pops a new job only after the last beat of its previous job;
//   a 4-entry job queue absorbs bursts, so input stalls only when it fills.
// Reset (synchronous, rst_n low): row 0, debounce counters 0, all keys released,
//   config back to debounce 10, note base 0, channel 0; queue and output emptied.
module button_matrix_scan_debounce import bmsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_not_empty;
  job_t q_job, q_head;
  logic cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ticks <= DEBOUNCE_DEFAULT;
      cfg_r.note_base     <= '0;
      cfg_r.midi_channel  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOCKOUT_TICKS: cfg_r.lockout_ticks <= pwdata[7:0];
        REG_NOTE_BASE:     cfg_r.note_base     <= pwdata[6:0];
        REG_MIDI_CHANNEL:  cfg_r.midi_channel  <= pwdata[3:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOCKOUT_TICKS: prdata = {24'd0, cfg_r.lockout_ticks};
      REG_NOTE_BASE:     prdata = {25'd0, cfg_r.note_base};
      REG_MIDI_CHANNEL:  prdata = {28'd0, cfg_r.midi_channel};
      default:           prdata = '0;
    endcase
  end

  bmsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  bmsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bmsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

`ifndef SYNTH
  // a non-event beat always closes its item
  a_idle_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.event_valid |-> out_data.last_result)
    else $error("non-event result without last flag");

  // velocity must agree with the release flag
  a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_valid |->
      ((out_data.released && out_data.velocity == 7'd0) ||
       (!out_data.released && out_data.velocity == VEL_PRESS)))
    else $error("velocity does not match key direction");

  // a pop only happens with a job available
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for button_matrix_scan_debounce: row scan beats in, key events out.
// Needs bmsd_pkg and the RTL. Each result beat is predicted by a local model of the scanner.
module tb_top;
  import bmsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 12;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  button_matrix_scan_debounce dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // scanner model state and register copies
  logic [2:0] scan_row;
  logic [7:0] settle_count [NUM_MATRICES];
  logic [7:0] key_state [NUM_MATRICES*ROWS];
  logic [7:0] reg_reload;
  logic [6:0] reg_note_base;
  logic [3:0] reg_channel;

  // stimulus-side view of what was sent, used to build plausible scans
  logic [2:0] gen_row;
  logic [7:0] gen_bits [NUM_MATRICES*ROWS];

  in_item_t  pending_items[$];
  out_item_t expected_beats[$];

  int cycle_count = 0;
  int error_count = 0;
  int rows_sent = 0;
  int beats_checked = 0;
  int key_events = 0;
  int config_writes = 0;
  int hold_requests = 0;
  int holds_done = 0;

  task automatic predict_row(input in_item_t beat);
    logic [1:0] m;
    logic [2:0] row;
    logic [7:0] changed;
    logic [7:0] now;
    logic [7:0] drive;
    out_item_t  evt [8];
    int         slot;
    int         n;
    int         p;
    m = beat.matrix_index;
    row = scan_row;
    changed = '0;
    now = ALL_RELEASED;
    if (int'(m) < NUM_MATRICES) begin
      slot = int'(m) * ROWS + int'(row);
      if (settle_count[m] != 0) settle_count[m]--;
      if (settle_count[m] == 0) begin
        changed = beat.row_bits ^ key_state[slot];
        key_state[slot] = beat.row_bits;
        now = beat.row_bits;
        if (changed != 0) settle_count[m] = reg_reload;
      end
    end
    if (beat.end_of_scan) scan_row = scan_row + 3'd1;
    // drive reflects the row after the advance, key numbers the row before it
    drive = ~(8'd1 << scan_row);
    n = 0;
    for (p = 0; p < 8; p++) begin
      if (changed[p]) begin
        evt[n] = '0;
        evt[n].row_drive = drive;
        evt[n].event_valid = 1'b1;
        evt[n].event_matrix = m;
        evt[n].key_number = {row, p[2:0]};
        evt[n].released = now[p];
        evt[n].note_number = reg_note_base + {1'b0, row, p[2:0]};
        evt[n].velocity = now[p] ? 7'd0 : VEL_PRESS;
        evt[n].event_channel = reg_channel;
        n++;
      end
    end
    if (n == 0) begin
      evt[0] = '0;
      evt[0].row_drive = drive;
      n = 1;
    end
    evt[n-1].last_result = 1'b1;
    for (p = 0; p < n; p++) expected_beats.push_back(evt[p]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (error_count < 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // prediction on accepted row beats, checking on accepted result beats
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_row(in_data);
        rows_sent++;
      end
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (out_data.event_valid === 1'b1) key_events++;
        if (expected_beats.size() == 0) begin
          if (error_count < 100)
            $display("%0t: result beat with nothing expected, expected none, actual %p",
                     $time, out_data);
          error_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("row_drive", want.row_drive, out_data.row_drive);
          check_field("event_valid", want.event_valid, out_data.event_valid);
          check_field("event_matrix", want.event_matrix, out_data.event_matrix);
          check_field("key_number", want.key_number, out_data.key_number);
          check_field("released", want.released, out_data.released);
          check_field("note_number", want.note_number, out_data.note_number);
          check_field("velocity", want.velocity, out_data.velocity);
          check_field("event_channel", want.event_channel, out_data.event_channel);
          check_field("last_result", want.last_result, out_data.last_result);
        end
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall style is redrawn when its random run ends; long holds on request
  stall_style_t stall_style = STALL_NONE;
  int style_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= ((cycle_count % 5) < 2);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d result beats outstanding", expected_beats.size());
      $display("button_matrix_scan_debounce verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_LOCKOUT_TICKS: reg_reload = value[7:0];
      REG_NOTE_BASE:     reg_note_base = value[6:0];
      REG_MIDI_CHANNEL:  reg_channel = value[3:0];
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic queue_row(input logic [1:0] m, input logic [7:0] bits, input logic eos);
    in_item_t beat;
    beat.matrix_index = m;
    beat.row_bits = bits;
    beat.end_of_scan = eos;
    pending_items.push_back(beat);
    if (int'(m) < NUM_MATRICES) gen_bits[int'(m) * ROWS + int'(gen_row)] = bits;
    if (eos) gen_row = gen_row + 3'd1;
  endtask

  // Waits for the block to drain, sets the registers, then queues mostly full row
  // scans (all matrices, eos on the last) with occasional key changes, plus stray beats.
  task automatic run_phase(input logic [7:0] reload, input logic [6:0] base,
                           input logic [3:0] chan, input int n_items, input bit long_hold);
    int queued;
    int m;
    logic [7:0] bits;
    wait_idle();
    write_reg(REG_LOCKOUT_TICKS, {24'd0, reload});
    write_reg(REG_NOTE_BASE, {25'd0, base});
    write_reg(REG_MIDI_CHANNEL, {28'd0, chan});
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        for (m = 0; m < NUM_MATRICES; m++) begin
          bits = gen_bits[m * ROWS + int'(gen_row)];
          case ($urandom_range(0, 9))
            0, 1: bits = bits ^ (8'd1 << $urandom_range(0, 7));
            2:    bits = 8'($urandom);
            default: ;
          endcase
          queue_row(m[1:0], bits, m == NUM_MATRICES - 1);
        end
        queued += NUM_MATRICES;
      end else begin
        queue_row(2'($urandom), 8'($urandom), $urandom_range(0, 4) == 0);
        queued++;
      end
    end
    if (long_hold) hold_requests++;
  endtask

  initial begin
    int i;
    scan_row = '0;
    gen_row = '0;
    for (i = 0; i < NUM_MATRICES; i++) settle_count[i] = '0;
    for (i = 0; i < NUM_MATRICES * ROWS; i++) begin
      key_state[i] = ALL_RELEASED;
      gen_bits[i] = ALL_RELEASED;
    end
    reg_reload = DEBOUNCE_DEFAULT;
    reg_note_base = '0;
    reg_channel = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: single press, all eight pressed, no change, top pin,
    // then changes swallowed while debounce runs, then row wrap
    queue_row(2'd0, 8'hfe, 1'b0);
    queue_row(2'd1, 8'h00, 1'b0);
    queue_row(2'd2, 8'hff, 1'b0);
    queue_row(2'd3, 8'h7f, 1'b1);
    queue_row(2'd0, 8'hff, 1'b0);
    queue_row(2'd1, 8'hff, 1'b1);
    for (i = 0; i < 6; i++) queue_row(2'd2, 8'hff, 1'b1);

    // zero reload, notes wrapping past 127, top channel
    run_phase(8'd0, 7'd127, 4'd15, 0, 1'b0);
    queue_row(2'd0, 8'h00, 1'b0);
    queue_row(2'd0, 8'hff, 1'b0);
    queue_row(2'd1, 8'hff, 1'b1);
    queue_row(2'd3, 8'h80, 1'b0);
    queue_row(2'd3, 8'h80, 1'b1);

    // reload of one: the very next beat for the matrix is seen again
    run_phase(8'd1, 7'h55, 4'd9, 0, 1'b0);
    queue_row(2'd2, 8'h00, 1'b0);
    queue_row(2'd2, 8'hff, 1'b0);
    queue_row(2'd2, 8'haa, 1'b0);

    run_phase(8'd3, 7'd0, 4'd0, 60, 1'b0);
    run_phase(8'd0, 7'd127, 4'd15, 60, 1'b1);
    run_phase(8'd255, 7'd64, 4'd3, 40, 1'b0);
    run_phase(8'($urandom_range(0, 4)), 7'($urandom), 4'($urandom), 70, 1'b0);
    run_phase(8'd1, 7'($urandom), 4'($urandom), 70, 1'b0);
    wait_idle();

    $display("covered %0d row beats, %0d result beats (%0d key events), %0d register writes",
             rows_sent, beats_checked, key_events, config_writes);
    $display("reloads 0, 1, 3 and 255, note base 0 to 127, long output hold included");
    if (error_count == 0) begin
      $display("button_matrix_scan_debounce verification clean");
    end else begin
      $display("button_matrix_scan_debounce verification failed");
    end
    $finish;
  end

endmodule
